// ----- src/um3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// um3_pkg: shared constants and types of the median-of-three range filter
// Sensor count, window depth, default distance width and control bundle.
// ----------------------------------------------------------------------------
package um3_pkg;

    // sensor count is fixed by the named ports a..d
    localparam int SENSORS        = 4;
    // window rows per sensor
    localparam int DEPTH          = 3;
    localparam int DIST_BITS_DEF  = 16;
    // result for a sensor with no valid window entry: -1 cm in 1/32 cm
    localparam int INVALID_DIST   = -32;

    // control from the top level to the window store
    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic advance;  // pending result moves into the output register
    } win_ctrl_t;

endpackage

// ----- src/um3_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// um3_window: three-deep ring of scans per sensor
// Writes each accepted scan over the oldest row, counts priming scans and
// flags when the stored window holds a scan whose result is still due.
// ----------------------------------------------------------------------------
module um3_window #(
    parameter int DIST_BITS = um3_pkg::DIST_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  um3_pkg::win_ctrl_t   ctrl,
    input  logic [DIST_BITS-1:0] dist_in  [um3_pkg::SENSORS],
    input  logic                 ok_in    [um3_pkg::SENSORS],
    output logic [DIST_BITS-1:0] win_dist [um3_pkg::DEPTH][um3_pkg::SENSORS],
    output logic                 win_ok   [um3_pkg::DEPTH][um3_pkg::SENSORS],
    output logic                 pending
);

    localparam logic [1:0] LAST_SLOT = 2'(um3_pkg::DEPTH - 1);
    localparam logic [1:0] PRIMED    = 2'(um3_pkg::DEPTH);

    logic [DIST_BITS-1:0] dist_reg [um3_pkg::DEPTH][um3_pkg::SENSORS];
    logic                 ok_reg   [um3_pkg::DEPTH][um3_pkg::SENSORS];
    logic [1:0]           slot_reg, slot_next;
    logic [1:0]           prime_reg, prime_next;
    logic                 pending_reg, pending_next;

    always_comb
    begin
        slot_next    = slot_reg;
        prime_next   = prime_reg;
        pending_next = pending_reg;
        if (ctrl.advance)
        begin
            pending_next = 1'b0;
        end
        if (ctrl.accept)
        begin
            slot_next = (slot_reg == LAST_SLOT) ? 2'd0 : slot_reg + 2'd1;
            if (prime_reg == PRIMED)
            begin
                pending_next = 1'b1;
            end
            else
            begin
                prime_next = prime_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= 2'd0;
            prime_reg   <= 2'd0;
            pending_reg <= 1'b0;
            for (int r = 0; r < um3_pkg::DEPTH; r++)
            begin
                for (int s = 0; s < um3_pkg::SENSORS; s++)
                begin
                    ok_reg[r][s] <= 1'b0;
                end
            end
        end
        else
        begin
            slot_reg    <= slot_next;
            prime_reg   <= prime_next;
            pending_reg <= pending_next;
            if (ctrl.accept)
            begin
                for (int s = 0; s < um3_pkg::SENSORS; s++)
                begin
                    ok_reg[slot_reg][s] <= ok_in[s];
                end
            end
        end
    end

    // distances are masked by their flags, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            for (int s = 0; s < um3_pkg::SENSORS; s++)
            begin
                dist_reg[slot_reg][s] <= dist_in[s];
            end
        end
    end

    assign win_dist = dist_reg;
    assign win_ok   = ok_reg;
    assign pending  = pending_reg;

endmodule

// ----- src/um3_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// um3_lane: one sensor lane of the range filter
// Takes one sensor's column of the window and hands it to the filter.
// ----------------------------------------------------------------------------
module um3_lane #(
    parameter int DIST_BITS = um3_pkg::DIST_BITS_DEF
) (
    input  logic [DIST_BITS-1:0]        dist_col [um3_pkg::DEPTH],
    input  logic                        ok_col   [um3_pkg::DEPTH],
    output logic signed [DIST_BITS+1:0] filt,
    output logic                        good
);

    um3_filter #(
        .DIST_BITS (DIST_BITS)
    ) u_filter (
        .dist_col (dist_col),
        .ok_col   (ok_col),
        .filt     (filt),
        .good     (good)
    );

endmodule

// ----- src/um3_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// um3_filter: filter of one sensor's three-entry window
// Median of three, pair average, single value or invalid, in 1/32 cm.
// ----------------------------------------------------------------------------
module um3_filter #(
    parameter int DIST_BITS = um3_pkg::DIST_BITS_DEF
) (
    input  logic [DIST_BITS-1:0]        dist_col [um3_pkg::DEPTH],
    input  logic                        ok_col   [um3_pkg::DEPTH],
    output logic signed [DIST_BITS+1:0] filt,
    output logic                        good
);

    localparam int OUT_BITS = DIST_BITS + 2;

    logic [DIST_BITS-1:0] m0, m1, m2;
    logic [DIST_BITS:0]   pair_sum;
    logic [DIST_BITS-1:0] lo01, hi01, hi_c, med;
    logic [1:0]           n_ok;
    logic [OUT_BITS-1:0]  res;

    // invalid entries drop out of the sum
    assign m0 = ok_col[0] ? dist_col[0] : '0;
    assign m1 = ok_col[1] ? dist_col[1] : '0;
    assign m2 = ok_col[2] ? dist_col[2] : '0;
    assign pair_sum = {1'b0, m0} + {1'b0, m1} + {1'b0, m2};

    // median = max(min(a,b), min(max(a,b),c))
    assign lo01 = (dist_col[0] < dist_col[1]) ? dist_col[0] : dist_col[1];
    assign hi01 = (dist_col[0] < dist_col[1]) ? dist_col[1] : dist_col[0];
    assign hi_c = (hi01 < dist_col[2]) ? hi01 : dist_col[2];
    assign med  = (lo01 > hi_c) ? lo01 : hi_c;

    assign n_ok = {1'b0, ok_col[0]} + {1'b0, ok_col[1]} + {1'b0, ok_col[2]};

    always_comb
    begin
        case (n_ok)
            2'd0:    res = OUT_BITS'(um3_pkg::INVALID_DIST);
            2'd1:    res = {pair_sum, 1'b0};
            2'd2:    res = {1'b0, pair_sum};
            default: res = {1'b0, med, 1'b0};
        endcase
    end

    assign filt = signed'(res);
    assign good = ok_col[0] | ok_col[1] | ok_col[2];

endmodule

// ----- src/ultrasonic_median3_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_median3_filter: median-of-three filter for four range sensors
// Top level: input handshake, window store, per-sensor filters, result reg.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall carry one scan per beat, a distance
//   (1/16 cm) and a valid flag for each of sensors a..d.
//   Output channel: out_valid / out_stall carry one result beat per scan
//   once the window is primed: filtered distance (1/32 cm, signed) and a
//   good flag per sensor; filt is -32 when good is low.
//   The first three scans after reset only fill the window, no beat out.
//   A taken scan stays pending in the window until the result reg is free.
//   Throughput: one scan per cycle unless stalled; the window registers feed
//   the four filters in parallel, so only the result register sets the pace.
//   Reset: window flags, ring slot, priming count and both valid bits
//   clear; the block then primes again.
//   Stall: a stalled result holds; one more scan can be taken into the
//   window, after that in_stall follows out_stall.
// ----------------------------------------------------------------------------
module ultrasonic_median3_filter #(
    parameter int DIST_BITS = um3_pkg::DIST_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [DIST_BITS-1:0]        dist_a,
    input  logic [DIST_BITS-1:0]        dist_b,
    input  logic [DIST_BITS-1:0]        dist_c,
    input  logic [DIST_BITS-1:0]        dist_d,
    input  logic                        ok_a,
    input  logic                        ok_b,
    input  logic                        ok_c,
    input  logic                        ok_d,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [DIST_BITS+1:0] filt_a,
    output logic signed [DIST_BITS+1:0] filt_b,
    output logic signed [DIST_BITS+1:0] filt_c,
    output logic signed [DIST_BITS+1:0] filt_d,
    output logic                        good_a,
    output logic                        good_b,
    output logic                        good_c,
    output logic                        good_d
);

    localparam int OUT_BITS = DIST_BITS + 2;
    localparam logic signed [OUT_BITS-1:0] INVALID = OUT_BITS'(um3_pkg::INVALID_DIST);

    um3_pkg::win_ctrl_t   ctrl;
    logic [DIST_BITS-1:0] dist_in  [um3_pkg::SENSORS];
    logic                 ok_in    [um3_pkg::SENSORS];
    logic [DIST_BITS-1:0] win_dist [um3_pkg::DEPTH][um3_pkg::SENSORS];
    logic                 win_ok   [um3_pkg::DEPTH][um3_pkg::SENSORS];
    logic                 win_pending;
    logic                 out_free;

    logic signed [OUT_BITS-1:0] lane_filt [um3_pkg::SENSORS];
    logic                       lane_good [um3_pkg::SENSORS];

    logic                       out_valid_reg, out_valid_next;
    logic signed [OUT_BITS-1:0] filt_reg [um3_pkg::SENSORS];
    logic                       good_reg [um3_pkg::SENSORS];

    assign dist_in[0] = dist_a;
    assign dist_in[1] = dist_b;
    assign dist_in[2] = dist_c;
    assign dist_in[3] = dist_d;
    assign ok_in[0]   = ok_a;
    assign ok_in[1]   = ok_b;
    assign ok_in[2]   = ok_c;
    assign ok_in[3]   = ok_d;

    // result register empties or hands its beat on this cycle
    assign out_free     = !out_valid_reg || !out_stall;
    // window may be overwritten once its pending result moves on
    assign ctrl.advance = win_pending && out_free;
    assign in_stall     = win_pending && !out_free;
    assign ctrl.accept  = in_valid && !in_stall;

    um3_window #(
        .DIST_BITS (DIST_BITS)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .dist_in  (dist_in),
        .ok_in    (ok_in),
        .win_dist (win_dist),
        .win_ok   (win_ok),
        .pending  (win_pending)
    );

    // one filter per sensor, each sees its own column of the window
    for (genvar s = 0; s < um3_pkg::SENSORS; s++)
    begin : g_lane
        logic [DIST_BITS-1:0] col_dist [um3_pkg::DEPTH];
        logic                 col_ok   [um3_pkg::DEPTH];

        for (genvar r = 0; r < um3_pkg::DEPTH; r++)
        begin : g_row
            assign col_dist[r] = win_dist[r][s];
            assign col_ok[r]   = win_ok[r][s];
        end

        um3_lane #(
            .DIST_BITS (DIST_BITS)
        ) u_lane (
            .dist_col (col_dist),
            .ok_col   (col_ok),
            .filt     (lane_filt[s]),
            .good     (lane_good[s])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = win_pending;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int s = 0; s < um3_pkg::SENSORS; s++)
            begin
                filt_reg[s] <= lane_filt[s];
                good_reg[s] <= lane_good[s];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign filt_a    = filt_reg[0];
    assign filt_b    = filt_reg[1];
    assign filt_c    = filt_reg[2];
    assign filt_d    = filt_reg[3];
    assign good_a    = good_reg[0];
    assign good_b    = good_reg[1];
    assign good_c    = good_reg[2];
    assign good_d    = good_reg[3];

`ifndef ASSERT_OFF
    // input backs up only behind a pending window result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (win_pending && out_valid_reg && out_stall))
        else $error("in_stall without a blocked pending result");

    // a pending result reaches an empty output register next cycle
    a_pending_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (win_pending && !out_valid_reg) |=> out_valid_reg)
        else $error("pending result not loaded");

    // taken beat with nothing pending leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !win_pending) |=> !out_valid_reg)
        else $error("result beat repeated");

    // an invalid sensor result carries the -1 cm marker
    a_invalid_a: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !good_reg[0]) |-> (filt_reg[0] == INVALID))
        else $error("invalid result without marker distance");
`endif

endmodule
